FILE: rtl/segrel_pkg.sv
// Shared constants for the segment relation classifier.
// Holds the default coordinate width and the relation codes; no dependencies.
package segrel_pkg;

  // Default coordinate width in bits
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Relation code width and values
  localparam int unsigned REL_WIDTH = 2;

  typedef enum logic [REL_WIDTH-1:0] {
    REL_DISJOINT = 2'd0,
    REL_CROSS    = 2'd1,
    REL_PARTIAL  = 2'd2,
    REL_CONTAIN  = 2'd3
  } rel_code_t;

endpackage

FILE: rtl/segment_relation_classifier.sv
// Segment relation classifier: three-stage pipeline from endpoints to class code.
// Depends on segrel_pkg for the default width and the relation codes.
//
// Usage:
//   Input channel: drive in_ax .. in_dy with the endpoints of segments AB and
//   CD and raise start for one cycle per request. A request is taken at every
//   rising edge where start is high and busy is low; busy stays low, so a new
//   request may be issued in every cycle.
//   Result channel: out_valid pulses for one cycle with out_relation_code
//   (0 disjoint, 1 cross or touch, 2 collinear partial overlap, 3 collinear
//   containment). The receiver cannot stall; results appear in request order.
//   Path: input register, then product registers, then code register, which
//   drives the result. Throughput: one request per cycle, set by the stage
//   split (input register, cross-product multipliers, sign and order compare).
//   Reset: rst_n low at a rising edge empties the pipeline; no result is
//   issued for requests that were in flight.
module segment_relation_classifier
  import segrel_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_ax,
  input  logic signed [COORD_WIDTH-1:0] in_ay,
  input  logic signed [COORD_WIDTH-1:0] in_bx,
  input  logic signed [COORD_WIDTH-1:0] in_by_coord,
  input  logic signed [COORD_WIDTH-1:0] in_cx,
  input  logic signed [COORD_WIDTH-1:0] in_cy,
  input  logic signed [COORD_WIDTH-1:0] in_dx,
  input  logic signed [COORD_WIDTH-1:0] in_dy,
  output logic                          out_valid,
  output logic        [REL_WIDTH-1:0]   out_relation_code
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;       // coordinate difference
  localparam int unsigned PW = 2 * W + 2;   // product of two differences
  localparam int unsigned CW = 2 * W + 3;   // cross product

  typedef logic signed [W-1:0]  coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cross_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } pts_t;

  // Lexicographic less-than on (x, y)
  function automatic logic lex_lt(input coord_t px, input coord_t py,
                                  input coord_t qx, input coord_t qy);
    lex_lt = (px < qx) || ((px == qx) && (py < qy));
  endfunction

  function automatic logic pt_eq(input coord_t px, input coord_t py,
                                 input coord_t qx, input coord_t qy);
    pt_eq = (px == qx) && (py == qy);
  endfunction

  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    sub_ext = diff_t'(a) - diff_t'(b);
  endfunction

  // Pipeline control and payload
  logic   v0_r, v1_r, v2_r;
  pts_t   pts0_r, pts1_r;
  prod_t  prod_p_r [4];
  prod_t  prod_q_r [4];
  logic [REL_WIDTH-1:0] code_r, code_nxt;

  // Stage 1 operands: orientation i is (Q-P)x*(R-P)y - (Q-P)y*(R-P)x
  diff_t qpx [4], qpy [4], rpx [4], rpy [4];

  assign busy = 1'b0;

  always_comb begin
    // o1: A,B,C   o2: A,B,D   o3: C,D,A   o4: C,D,B
    qpx[0] = sub_ext(pts0_r.bx, pts0_r.ax);  qpy[0] = sub_ext(pts0_r.by, pts0_r.ay);
    rpx[0] = sub_ext(pts0_r.cx, pts0_r.ax);  rpy[0] = sub_ext(pts0_r.cy, pts0_r.ay);
    qpx[1] = qpx[0];                         qpy[1] = qpy[0];
    rpx[1] = sub_ext(pts0_r.dx, pts0_r.ax);  rpy[1] = sub_ext(pts0_r.dy, pts0_r.ay);
    qpx[2] = sub_ext(pts0_r.dx, pts0_r.cx);  qpy[2] = sub_ext(pts0_r.dy, pts0_r.cy);
    rpx[2] = sub_ext(pts0_r.ax, pts0_r.cx);  rpy[2] = sub_ext(pts0_r.ay, pts0_r.cy);
    qpx[3] = qpx[2];                         qpy[3] = qpy[2];
    rpx[3] = sub_ext(pts0_r.bx, pts0_r.cx);  rpy[3] = sub_ext(pts0_r.by, pts0_r.cy);
  end

  // Stage 2: orientation signs and collinear interval test
  cross_t cr [4];
  logic   pos [4], neg [4];
  logic   collinear, same1, same2;
  coord_t sax, say, sbx, sby, scx, scy, sdx, sdy;
  logic   swap_ab, swap_cd;
  logic   ac_lt, ac_gt, bc_lt, bc_eq, bc_gt, da_lt, da_eq, da_gt, bd_lt, bd_gt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cr[i]  = cross_t'(prod_p_r[i]) - cross_t'(prod_q_r[i]);
      neg[i] = cr[i][CW-1];
      pos[i] = !cr[i][CW-1] && (cr[i] != '0);
    end
    collinear = !pos[0] && !neg[0] && !pos[1] && !neg[1] &&
                !pos[2] && !neg[2] && !pos[3] && !neg[3];
    same1 = (pos[0] && pos[1]) || (neg[0] && neg[1]);
    same2 = (pos[2] && pos[3]) || (neg[2] && neg[3]);

    // Order each segment's endpoints
    swap_ab = lex_lt(pts1_r.bx, pts1_r.by, pts1_r.ax, pts1_r.ay);
    swap_cd = lex_lt(pts1_r.dx, pts1_r.dy, pts1_r.cx, pts1_r.cy);
    sax = swap_ab ? pts1_r.bx : pts1_r.ax;  say = swap_ab ? pts1_r.by : pts1_r.ay;
    sbx = swap_ab ? pts1_r.ax : pts1_r.bx;  sby = swap_ab ? pts1_r.ay : pts1_r.by;
    scx = swap_cd ? pts1_r.dx : pts1_r.cx;  scy = swap_cd ? pts1_r.dy : pts1_r.cy;
    sdx = swap_cd ? pts1_r.cx : pts1_r.dx;  sdy = swap_cd ? pts1_r.cy : pts1_r.dy;

    ac_lt = lex_lt(sax, say, scx, scy);
    ac_gt = lex_lt(scx, scy, sax, say);
    bc_lt = lex_lt(sbx, sby, scx, scy);
    bc_eq = pt_eq(sbx, sby, scx, scy);
    bc_gt = !bc_lt && !bc_eq;
    da_lt = lex_lt(sdx, sdy, sax, say);
    da_eq = pt_eq(sdx, sdy, sax, say);
    da_gt = !da_lt && !da_eq;
    bd_lt = lex_lt(sbx, sby, sdx, sdy);
    bd_gt = lex_lt(sdx, sdy, sbx, sby);

    // Pick the relation code
    if (collinear) begin
      if (bc_lt || da_lt) begin
        code_nxt = REL_DISJOINT;
      end else if ((ac_lt && bc_eq) || (ac_gt && da_eq)) begin
        code_nxt = REL_CROSS;
      end else if ((ac_lt && bc_gt && bd_lt) || (ac_gt && da_gt && bd_gt)) begin
        code_nxt = REL_PARTIAL;
      end else begin
        code_nxt = REL_CONTAIN;
      end
    end else if (!same1 && !same2) begin
      code_nxt = REL_CROSS;
    end else begin
      code_nxt = REL_DISJOINT;
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Hold the payload of each stage
  always_ff @(posedge clk) begin
    pts0_r <= '{ax: in_ax, ay: in_ay, bx: in_bx, by: in_by_coord,
                cx: in_cx, cy: in_cy, dx: in_dx, dy: in_dy};
    pts1_r <= pts0_r;
    for (int i = 0; i < 4; i++) begin
      prod_p_r[i] <= PW'(qpx[i] * rpy[i]);
      prod_q_r[i] <= PW'(qpy[i] * rpx[i]);
    end
    code_r <= code_nxt;
  end

  assign out_valid         = v2_r;
  assign out_relation_code = code_r;

endmodule
